### sv/byte_ring_buffer_fifo_assert.svh
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_assert.svh
// assertion macros shared by the ring buffer checks
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_FIFO_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_ASSERT_SVH

// same-cycle implication
`define BRBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer assertion failed");

// next-cycle implication
`define BRBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer assertion failed");

`endif

### sv/brbf_pkg.sv
// ----------------------------------------------------------------------------
// brbf_pkg
// types and constants of the byte ring buffer fifo
// ----------------------------------------------------------------------------
package brbf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 56;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [POS_W-1:0] MIN_SLOTS = 9'd2;

  // register index taken from paddr[2]
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH     = 3'd0,
    ACT_POP      = 3'd1,
    ACT_ADV_READ = 3'd2,
    ACT_ADV_WRITE = 3'd3,
    ACT_QUERY    = 3'd4
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_LENGTH = 2'd3
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] used;
    logic [BYTE_W-1:0] free;
    logic [BYTE_W-1:0] rspan;
    logic [BYTE_W-1:0] wspan;
  } span_t;

endpackage

### sv/brbf_span.sv
// ----------------------------------------------------------------------------
// brbf_span
// fill level and contiguous spans from the two ring indices
// ----------------------------------------------------------------------------
module brbf_span (
  input  logic [brbf_pkg::POS_W-1:0] wp_i,
  input  logic [brbf_pkg::POS_W-1:0] rp_i,
  input  logic [brbf_pkg::POS_W-1:0] slots_i,
  output brbf_pkg::span_t            span_o
);
  import brbf_pkg::*;

  logic [POS_W-1:0] used;
  logic [POS_W-1:0] free;
  logic [POS_W-1:0] rspan;
  logic [POS_W-1:0] to_end;
  logic [POS_W-1:0] wspan;

  always_comb begin
    if (wp_i >= rp_i) begin
      used = wp_i - rp_i;
    end else begin
      used = slots_i + wp_i - rp_i;
    end
    free = slots_i - 9'd1 - used;

    if (wp_i == rp_i) begin
      rspan = '0;
    end else if (wp_i > rp_i) begin
      rspan = wp_i - rp_i;
    end else begin
      rspan = slots_i - rp_i;
    end

    to_end = slots_i - wp_i;
    wspan  = (free < to_end) ? free : to_end;
  end

  assign span_o.used  = used[BYTE_W-1:0];
  assign span_o.free  = free[BYTE_W-1:0];
  assign span_o.rspan = rspan[BYTE_W-1:0];
  assign span_o.wspan = wspan[BYTE_W-1:0];

endmodule

### sv/byte_ring_buffer_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo
// byte circular fifo with push, pop, index advance and query, one result each
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: action, tdata: push_byte, step_length
// m_axis    out  tuser: status, tdata: popped byte, counts, spans, indices
// apb       in   slots_in_use at byte address 0
//
// one word per cycle; the result shows in the cycle after acceptance
// the popped byte comes from the store's registered read port
// input stalls only while a result waits in the output register
// reset clears both indices and sets the size to min(DEPTH, 256)
// the store is not cleared; no startup pass
// ----------------------------------------------------------------------------
module byte_ring_buffer_fifo #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] push_byte, [16:8] step_length, [23:17] zero
  input  logic [brbf_pkg::IN_W-1:0]     s_axis_tdata,
  // [2:0] action
  input  logic [brbf_pkg::ACT_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] popped_byte, [15:8] used_count, [23:16] free_count,
  // [31:24] read_span, [39:32] write_span, [47:40] read_index,
  // [55:48] write_index
  output logic [brbf_pkg::OUT_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [brbf_pkg::STAT_W-1:0]   m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brbf_pkg::APB_AW-1:0]   paddr,
  input  logic [brbf_pkg::APB_DW-1:0]   pwdata,
  output logic [brbf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import brbf_pkg::*;

  localparam int unsigned MemDepth = (DEPTH < 512) ? DEPTH : 512;
  localparam int unsigned AW       = $clog2(MemDepth);
  localparam logic [POS_W-1:0] MaxSlots   = POS_W'((DEPTH < 511) ? DEPTH : 511);
  localparam logic [POS_W-1:0] ResetSlots = POS_W'((DEPTH < 256) ? DEPTH : 256);

  logic [BYTE_W-1:0] mem [MemDepth];

  logic [POS_W-1:0]  wp_q, wp_d;
  logic [POS_W-1:0]  rp_q, rp_d;
  logic [POS_W-1:0]  slots_q;
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic              pop_ok_q, pop_ok_d;
  logic [BYTE_W-1:0] rdata_q;

  logic              accept;
  logic              cfg_wr;
  act_e              act;
  logic [BYTE_W-1:0] push_byte;
  logic [POS_W-1:0]  step_len;
  logic [POS_W-1:0]  push_nxt;
  logic              mem_we;
  logic              mem_re;
  logic [POS_W-1:0]  cfg_slots;
  span_t             span;

  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] idx,
                                                input logic [POS_W-1:0] len,
                                                input logic [POS_W-1:0] size);
    logic [POS_W:0] sum;
    sum = {1'b0, idx} + {1'b0, len};
    if (sum >= {1'b0, size}) begin
      sum = sum - {1'b0, size};
    end
    return sum[POS_W-1:0];
  endfunction

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign act           = act_e'(s_axis_tuser);
  assign push_byte     = s_axis_tdata[BYTE_W-1:0];
  assign step_len      = s_axis_tdata[BYTE_W+POS_W-1:BYTE_W];
  assign push_nxt      = wrap_add(wp_q, 9'd1, slots_q);

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    unique case (act)
      ACT_PUSH: begin
        if (push_nxt == rp_q) begin
          status_d = ST_FULL;
        end else begin
          mem_we = accept;
          wp_d   = push_nxt;
        end
      end
      ACT_POP: begin
        if (wp_q == rp_q) begin
          status_d = ST_EMPTY;
        end else begin
          mem_re   = accept;
          pop_ok_d = 1'b1;
          rp_d     = wrap_add(rp_q, 9'd1, slots_q);
        end
      end
      ACT_ADV_READ: begin
        if (step_len > slots_q) begin
          status_d = ST_LENGTH;
        end else begin
          rp_d = wrap_add(rp_q, step_len, slots_q);
        end
      end
      ACT_ADV_WRITE: begin
        if (step_len > slots_q) begin
          status_d = ST_LENGTH;
        end else begin
          wp_d = wrap_add(wp_q, step_len, slots_q);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS_IN_USE);

  always_comb begin
    cfg_slots = pwdata[POS_W-1:0];
    if (cfg_slots < MIN_SLOTS) begin
      cfg_slots = MIN_SLOTS;
    end else if (cfg_slots > MaxSlots) begin
      cfg_slots = MaxSlots;
    end
  end

  assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? APB_DW'(slots_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      slots_q     <= ResetSlots;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      pop_ok_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        slots_q <= cfg_slots;
        wp_q    <= '0;
        rp_q    <= '0;
      end else if (accept) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        pop_ok_q    <= pop_ok_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q[AW-1:0]] <= push_byte;
    end
    if (mem_re) begin
      rdata_q <= mem[rp_q[AW-1:0]];
    end
  end

  brbf_span u_span (
    .wp_i    (wp_q),
    .rp_i    (rp_q),
    .slots_i (slots_q),
    .span_o  (span)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {wp_q[BYTE_W-1:0], rp_q[BYTE_W-1:0], span.wspan, span.rspan,
                          span.free, span.used, pop_ok_q ? rdata_q : 8'd0};

endmodule

### sv/brbf_checker.sv
// ----------------------------------------------------------------------------
// brbf_checker
// port-level checks of the byte ring buffer fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_fifo_assert.svh"

module brbf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [brbf_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic [brbf_pkg::STAT_W-1:0]   m_axis_tuser
);
  import brbf_pkg::*;

  `BRBF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `BRBF_ASSERT_NXT(a_one_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   m_axis_tvalid)
  `BRBF_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                   m_axis_tvalid && !m_axis_tready)
  `BRBF_ASSERT_IMP(a_empty_pop, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_EMPTY),
                   (m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[31:24] == 8'd0))
  `BRBF_ASSERT_IMP(a_full_push, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_FULL),
                   (m_axis_tdata[23:16] == 8'd0) && (m_axis_tdata[39:32] == 8'd0))

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte ring buffer fifo: an opening table of
// words (push, pop, index advance, query, size writes at the limits), then
// random phases over several buffer sizes and idle patterns; every result
// word is checked against a typed table row or a bit-exact copy of the buffer
// ----------------------------------------------------------------------------
module tb;
  import brbf_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned N_PHASES    = 11;
  localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;
  localparam logic [APB_AW-1:0] SLOTS_ADDR = {REG_SLOTS_IN_USE, 2'b00};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [7:0]        write_idx;
    logic [7:0]        read_idx;
    logic [7:0]        wspan;
    logic [7:0]        rspan;
    logic [7:0]        free;
    logic [7:0]        used;
    logic [7:0]        popped;
  } ring_result_t;

  typedef struct {
    bit               is_cfg;
    bit               typed;
    logic [ACT_W-1:0] act;
    logic [7:0]       data;
    logic [8:0]       len;
    logic [31:0]      cfg;
    ring_result_t     res;
  } opening_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [ACT_W-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [STAT_W-1:0]   m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // software copy of the buffer
  logic [7:0]   store_copy [STORE_DEPTH];
  bit           store_set [STORE_DEPTH];
  int unsigned  wr_pos;
  int unsigned  rd_pos;
  int unsigned  n_slots;

  ring_result_t pending_results [$];
  opening_row_t opening_rows [$];

  int idle_mode;
  int sender_idle_pct [4] = '{0, 55, 0, 12};
  int rx_stall_pct [4]    = '{0, 0, 55, 12};
  bit hold_req;
  int unsigned cycle_count;
  int n_errors;
  int n_items;
  int n_results;
  int n_cfg;
  int status_tally [4];

  byte_ring_buffer_fifo #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned pos_add(int unsigned idx, int unsigned len);
    int unsigned s;
    s = idx + len;
    if (s >= n_slots) s -= n_slots;
    return s;
  endfunction

  // one step of the buffer, updates the copy and returns the result word
  function automatic ring_result_t ring_step(logic [ACT_W-1:0] act, logic [7:0] data,
                                             logic [8:0] len);
    ring_result_t res;
    int unsigned  nxt, used, free_n, to_end, rspan;
    res = '0;
    res.status = ST_OK;
    if (wr_pos >= n_slots) wr_pos = 0;
    if (rd_pos >= n_slots) rd_pos = 0;
    case (act)
      ACT_PUSH: begin
        nxt = pos_add(wr_pos, 1);
        if (nxt == rd_pos) begin
          res.status = ST_FULL;
        end else begin
          store_copy[wr_pos] = data;
          store_set[wr_pos] = 1'b1;
          wr_pos = nxt;
        end
      end
      ACT_POP: begin
        if (wr_pos == rd_pos) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = store_copy[rd_pos];
          rd_pos = pos_add(rd_pos, 1);
        end
      end
      ACT_ADV_READ, ACT_ADV_WRITE: begin
        if (len > n_slots) res.status = ST_LENGTH;
        else if (act == ACT_ADV_READ) rd_pos = pos_add(rd_pos, len);
        else wr_pos = pos_add(wr_pos, len);
      end
      default: ;
    endcase
    used = (wr_pos >= rd_pos) ? wr_pos - rd_pos : n_slots + wr_pos - rd_pos;
    free_n = n_slots - 1 - used;
    if (wr_pos == rd_pos) rspan = 0;
    else if (wr_pos > rd_pos) rspan = wr_pos - rd_pos;
    else rspan = n_slots - rd_pos;
    to_end = n_slots - wr_pos;
    res.used = used[7:0];
    res.free = free_n[7:0];
    res.rspan = rspan[7:0];
    res.wspan = (free_n < to_end) ? free_n[7:0] : to_end[7:0];
    res.read_idx = rd_pos[7:0];
    res.write_idx = wr_pos[7:0];
    return res;
  endfunction

  function automatic opening_row_t item_row(logic [ACT_W-1:0] act, logic [7:0] data,
                                            logic [8:0] len);
    opening_row_t row;
    row = '{default: '0};
    row.act = act;
    row.data = data;
    row.len = len;
    return row;
  endfunction

  function automatic opening_row_t typed_row(logic [ACT_W-1:0] act, logic [7:0] data,
      logic [8:0] len, status_e st, int popped, int used, int free, int rspan,
      int wspan, int ridx, int widx);
    opening_row_t row;
    row = item_row(act, data, len);
    row.typed = 1'b1;
    row.res = '{st, widx[7:0], ridx[7:0], wspan[7:0], rspan[7:0], free[7:0],
                used[7:0], popped[7:0]};
    return row;
  endfunction

  function automatic opening_row_t cfg_row(logic [31:0] value);
    opening_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg = value;
    return row;
  endfunction

  task automatic send_word(logic [ACT_W-1:0] act, logic [7:0] data, logic [8:0] len,
                           bit use_typed, ring_result_t typed_res);
    ring_result_t pred;
    while ($urandom_range(0, 99) < sender_idle_pct[idle_mode]) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - 17){1'b0}}, len, data};
    s_axis_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = ring_step(act, data, len);
    status_tally[pred.status]++;
    pending_results.push_back(use_typed ? typed_res : pred);
    n_items++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_slots(logic [31:0] value);
    logic [8:0] v9;
    drain_results();
    repeat (2) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLOTS_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v9 = value[8:0];
    if (v9 < MIN_SLOTS) n_slots = MIN_SLOTS;
    else if (v9 > STORE_DEPTH) n_slots = STORE_DEPTH;
    else n_slots = v9;
    wr_pos = 0;
    rd_pos = 0;
    n_cfg++;
  endtask

  task automatic random_word(int push_pct);
    int               r, s, short_max;
    logic [ACT_W-1:0] act;
    logic [7:0]       data;
    logic [8:0]       len;
    data = 8'($urandom_range(0, 255));
    len = 9'($urandom_range(0, 511));
    r = $urandom_range(0, 99);
    if (r < 7) act = ACT_ADV_READ;
    else if (r < 14) act = ACT_ADV_WRITE;
    else if (r < 20) act = ACT_W'($urandom_range(ACT_QUERY, ACT_RSVD_7));
    else act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
    if (act == ACT_ADV_READ || act == ACT_ADV_WRITE) begin
      s = $urandom_range(0, 9);
      short_max = (n_slots < 4) ? n_slots : 4;
      if (s < 6) len = 9'($urandom_range(0, short_max));
      else if (s < 9) len = 9'($urandom_range(0, n_slots));
      else len = 9'($urandom_range(n_slots + 1, 511));
    end
    // never pop a slot that was not written yet
    if (act == ACT_POP && wr_pos != rd_pos && !store_set[rd_pos]) begin
      act = ACT_ADV_READ;
      len = 9'd1;
    end
    send_word(act, data, len, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    ring_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("result word %h with nothing expected", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch at result %0d (st pop used free rspan wspan rd wr)", n_results);
            $display("  exp %0d %h %0d %0d %0d %0d %0d %0d", want.status, want.popped,
                     want.used, want.free, want.rspan, want.wspan, want.read_idx,
                     want.write_idx);
            $display("  got %0d %h %0d %0d %0d %0d %0d %0d", got.status, got.popped,
                     got.used, got.free, got.rspan, got.wspan, got.read_idx,
                     got.write_idx);
          end
        end
      end
    end
  end

  // receiver side
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct[idle_mode]);
      end
    end
  end

  initial begin
    int unsigned phase_cfg [N_PHASES] = '{256, 2, 3, 9, 16, 5, 128, 4, 17, 1, 400};
    int          phase_len [N_PHASES] = '{300, 100, 100, 120, 120, 100, 200, 100, 120,
                                          80, 280};
    int          push_pct;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_mode = 0;
    hold_req = 1'b0;
    wr_pos = 0;
    rd_pos = 0;
    n_slots = STORE_DEPTH;
    foreach (store_set[i]) begin
      store_set[i] = 1'b0;
      store_copy[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full size after reset
    opening_rows.push_back(typed_row(ACT_QUERY, 8'h00, 9'd0, ST_OK, 0, 0, 255, 0, 255, 0, 0));
    opening_rows.push_back(typed_row(ACT_POP, 8'h00, 9'd0, ST_EMPTY, 0, 0, 255, 0, 255, 0, 0));
    opening_rows.push_back(typed_row(ACT_PUSH, 8'hff, 9'd0, ST_OK, 0, 1, 254, 1, 254, 0, 1));
    opening_rows.push_back(typed_row(ACT_PUSH, 8'h00, 9'h1ff, ST_OK, 0, 2, 253, 2, 253, 0, 2));
    opening_rows.push_back(typed_row(ACT_POP, 8'h00, 9'd0, ST_OK, 8'hff, 1, 254, 1, 254, 1, 2));
    opening_rows.push_back(typed_row(ACT_ADV_READ, 8'h00, 9'd257, ST_LENGTH, 0, 1, 254, 1, 254,
                                     1, 2));
    opening_rows.push_back(typed_row(ACT_ADV_WRITE, 8'h00, 9'h1ff, ST_LENGTH, 0, 1, 254, 1,
                                     254, 1, 2));
    opening_rows.push_back(typed_row(ACT_RSVD_7, 8'haa, 9'h1ff, ST_OK, 0, 1, 254, 1, 254, 1, 2));
    opening_rows.push_back(item_row(ACT_ADV_WRITE, 8'h00, 9'd256));
    opening_rows.push_back(item_row(ACT_ADV_READ, 8'hff, 9'd0));
    // smallest size
    opening_rows.push_back(cfg_row(32'd2));
    opening_rows.push_back(typed_row(ACT_PUSH, 8'h5a, 9'd0, ST_OK, 0, 1, 0, 1, 0, 0, 1));
    opening_rows.push_back(typed_row(ACT_PUSH, 8'ha5, 9'd0, ST_FULL, 0, 1, 0, 1, 0, 0, 1));
    opening_rows.push_back(item_row(ACT_POP, 8'h00, 9'd0));
    opening_rows.push_back(item_row(ACT_ADV_WRITE, 8'h00, 9'd2));
    opening_rows.push_back(item_row(ACT_ADV_WRITE, 8'h00, 9'd3));
    // size below and above the legal range
    opening_rows.push_back(cfg_row(32'd0));
    opening_rows.push_back(typed_row(ACT_QUERY, 8'h00, 9'd0, ST_OK, 0, 0, 1, 0, 1, 0, 0));
    opening_rows.push_back(cfg_row(32'd511));
    opening_rows.push_back(typed_row(ACT_RSVD_5, 8'hff, 9'h1ff, ST_OK, 0, 0, 255, 0, 255, 0, 0));
    // upper write bits ignored, size 3
    opening_rows.push_back(cfg_row(32'hffff_fe03));
    opening_rows.push_back(item_row(ACT_PUSH, 8'h01, 9'h100));
    opening_rows.push_back(item_row(ACT_PUSH, 8'h80, 9'd0));
    opening_rows.push_back(item_row(ACT_PUSH, 8'h7f, 9'd0));
    opening_rows.push_back(item_row(ACT_ADV_READ, 8'h00, 9'd1));
    opening_rows.push_back(item_row(ACT_POP, 8'h00, 9'd0));
    opening_rows.push_back(item_row(ACT_POP, 8'h00, 9'd0));
    opening_rows.push_back(item_row(ACT_RSVD_6, 8'h00, 9'd0));

    foreach (opening_rows[i]) begin
      if (opening_rows[i].is_cfg) begin
        write_slots(opening_rows[i].cfg);
      end else begin
        send_word(opening_rows[i].act, opening_rows[i].data, opening_rows[i].len,
                  opening_rows[i].typed, opening_rows[i].res);
      end
    end

    push_pct = 50;
    for (int p = 0; p < N_PHASES; p++) begin
      write_slots(phase_cfg[p]);
      idle_mode = p % 4;
      for (int k = 0; k < phase_len[p]; k++) begin
        if (k % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 20;
            default: push_pct = 50;
          endcase
        end
        // long output stall while words keep coming, then a full drain
        if (k == phase_len[p] / 2) hold_req = 1'b1;
        if (k == phase_len[p] / 2 + 40) drain_results();
        random_word(push_pct);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("%0d words sent over %0d size writes, %0d results checked, %0d mismatches",
             n_items, n_cfg, n_results, n_errors);
    $display("status mix: ok %0d, full %0d, empty %0d, bad length %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_LENGTH]);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### byte_ring_buffer_fifo.f
+incdir+sv
sv/brbf_pkg.sv
sv/brbf_span.sv
sv/byte_ring_buffer_fifo.sv
sv/brbf_checker.sv
tb/sv/tb.sv
